// ----- rtl/lfu_pkg.sv -----
// shared constants and types for the lfu eviction policy table
`timescale 1ns / 1ps
package lfu_pkg;
    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_BITS   = 64;
    localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LIVE_BITS  = $clog2(CAPACITY + 1);
    localparam int RANK_BITS  = IDX_BITS;
    localparam int ENTRY_BITS = KEY_BITS + COUNT_BITS + RANK_BITS;

    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_EVICT  = 2'd2;
    localparam logic [1:0] OP_REMOVE = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // one stored entry
    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
        logic [RANK_BITS-1:0]  rank;
    } entry_t;

    // memory write request
    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        entry_t              data;
    } mem_wr_t;
endpackage

// ----- rtl/lfu_entry_ram.sv -----
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
module lfu_entry_ram (
    input  logic                         clk,
    input  logic [lfu_pkg::IDX_BITS-1:0] rd_addr,
    output lfu_pkg::entry_t              rd_data,
    input  lfu_pkg::mem_wr_t             wr
);
    import lfu_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    // synchronous write and read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- rtl/lfu_eviction_policy_table.sv -----
// lfu eviction policy table: top level with scan sequencer
// each request runs a scan pass over the entry memory, a decision step and, when the table changes,
// an update pass; requests are taken one at a time, the next only once the result has been taken
// both passes use the entry memory, which has one write port and one registered read port
// reset clears valid bits and live count; entry memory needs no clearing
`timescale 1ns / 1ps
module lfu_eviction_policy_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // op[1:0], key[65:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // status[1:0], victim_key[65:2], zero pad
);
    import lfu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;
    localparam logic [2:0] S_ACT   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [IDX_BITS:0]     cnt_reg;      // issue counter
    logic                  rvalid_reg;   // read data valid this cycle
    logic [IDX_BITS-1:0]   ridx_reg;     // index of read data
    logic [CAPACITY-1:0]   valid_reg;
    logic [LIVE_BITS-1:0]  live_reg;
    logic                  hit_reg, free_found_reg, vic_found_reg;
    logic [IDX_BITS-1:0]   hit_idx_reg, free_idx_reg, vic_idx_reg;
    logic [RANK_BITS-1:0]  hit_rank_reg, vic_rank_reg;
    logic [COUNT_BITS-1:0] hit_count_reg, vic_count_reg;
    logic [KEY_BITS-1:0]   vic_key_reg;
    // decision
    logic                  act_reg;      // a state change happens
    logic [1:0]            kind_reg;     // 0 touch, 1 insert, 2 drop
    logic [IDX_BITS-1:0]   tgt_reg;
    logic [RANK_BITS-1:0]  tgt_rank_reg;
    logic [COUNT_BITS-1:0] tgt_count_reg;
    logic [1:0]            status_reg;
    logic [KEY_BITS-1:0]   victim_reg;
    logic                  out_valid_reg;

    localparam logic [1:0] K_TOUCH  = 2'd0;
    localparam logic [1:0] K_INSERT = 2'd1;
    localparam logic [1:0] K_DROP   = 2'd2;

    logic [IDX_BITS-1:0] rd_addr;
    entry_t              rd_data;
    mem_wr_t             wr;

    lfu_entry_ram u_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign rd_addr  = cnt_reg[IDX_BITS-1:0];
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, victim_reg, status_reg};

    wire last_issue = (cnt_reg == (IDX_BITS+1)'(CAPACITY - 1));
    wire rd_live    = rvalid_reg && valid_reg[ridx_reg];

    // victim compare on streamed entry
    wire vic_better = !vic_found_reg || (rd_data.count < vic_count_reg) ||
                      ((rd_data.count == vic_count_reg) && (rd_data.rank > vic_rank_reg));

    // rank adjustment in the update pass, with the new count for a touched entry
    entry_t upd;
    logic   upd_en;
    always_comb
    begin
        upd    = rd_data;
        upd_en = 1'b0;
        if (rd_live)
        begin
            upd_en = 1'b1;
            if (ridx_reg == tgt_reg)
            begin
                if (kind_reg == K_TOUCH)
                begin
                    upd.rank  = '0;
                    upd.count = tgt_count_reg;
                end
                else
                begin
                    upd_en = 1'b0;
                end
            end
            else
            begin
                case (kind_reg)
                    K_TOUCH:  if (rd_data.rank < tgt_rank_reg) upd.rank = rd_data.rank + 1'b1;
                    K_INSERT: upd.rank = rd_data.rank + 1'b1;
                    K_DROP:   if (rd_data.rank > tgt_rank_reg) upd.rank = rd_data.rank - 1'b1;
                    default:  upd_en = 1'b0;
                endcase
            end
        end
    end

    // memory write select
    always_comb
    begin
        wr = '0;
        if (state_reg == S_ACT && act_reg && kind_reg == K_INSERT)
        begin
            wr.en   = 1'b1;
            wr.addr = tgt_reg;
            wr.data = '{key: key_reg, count: COUNT_BITS'(1), rank: '0};
        end
        else if (state_reg == S_UPD && upd_en)
        begin
            wr.en   = 1'b1;
            wr.addr = ridx_reg;
            wr.data = upd;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_SCAN;
            S_SCAN: if (rvalid_reg && ridx_reg == IDX_BITS'(CAPACITY - 1)) state_next = S_DEC;
            S_DEC:  state_next = S_ACT;
            S_ACT:  state_next = act_reg ? S_UPD : S_OUT;
            S_UPD:  if (rvalid_reg && ridx_reg == IDX_BITS'(CAPACITY - 1)) state_next = S_OUT;
            S_OUT:  if (out_valid_reg && m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            cnt_reg       <= '0;
            act_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // result valid from entry into output until taken
            if (state_reg != S_OUT && state_next == S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (s_tvalid)
                    begin
                        op_reg         <= s_tdata[1:0];
                        key_reg        <= s_tdata[KEY_BITS+1:2];
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        vic_found_reg  <= 1'b0;
                    end
                end
                S_SCAN, S_UPD:
                begin
                    rvalid_reg <= !cnt_reg[IDX_BITS];
                    if (!cnt_reg[IDX_BITS])
                    begin
                        ridx_reg   <= cnt_reg[IDX_BITS-1:0];
                        cnt_reg    <= last_issue ? {1'b1, {IDX_BITS{1'b0}}} : cnt_reg + 1'b1;
                    end
                    if (state_reg == S_SCAN && rvalid_reg)
                    begin
                        if (!valid_reg[ridx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= ridx_reg;
                        end
                        if (rd_live && rd_data.key == key_reg && !hit_reg)
                        begin
                            hit_reg       <= 1'b1;
                            hit_idx_reg   <= ridx_reg;
                            hit_rank_reg  <= rd_data.rank;
                            hit_count_reg <= rd_data.count;
                        end
                        if (rd_live && vic_better)
                        begin
                            vic_found_reg <= 1'b1;
                            vic_idx_reg   <= ridx_reg;
                            vic_rank_reg  <= rd_data.rank;
                            vic_count_reg <= rd_data.count;
                            vic_key_reg   <= rd_data.key;
                        end
                    end
                end
                S_DEC:
                begin
                    cnt_reg    <= '0;
                    status_reg <= ST_OK;
                    victim_reg <= '0;
                    act_reg    <= 1'b0;
                    case (op_reg)
                        OP_GET:
                        begin
                            if (hit_reg)
                            begin
                                act_reg       <= 1'b1;
                                kind_reg      <= K_TOUCH;
                                tgt_reg       <= hit_idx_reg;
                                tgt_rank_reg  <= hit_rank_reg;
                                tgt_count_reg <= (hit_count_reg == COUNT_MAX) ? COUNT_MAX
                                                 : hit_count_reg + 1'b1;
                            end
                            else status_reg <= ST_MISS;
                        end
                        OP_SET:
                        begin
                            if (hit_reg)
                            begin
                                act_reg       <= 1'b1;
                                kind_reg      <= K_TOUCH;
                                tgt_reg       <= hit_idx_reg;
                                tgt_rank_reg  <= hit_rank_reg;
                                tgt_count_reg <= COUNT_BITS'(1);
                            end
                            else if (free_found_reg)
                            begin
                                act_reg   <= 1'b1;
                                kind_reg  <= K_INSERT;
                                tgt_reg   <= free_idx_reg;
                                valid_reg[free_idx_reg] <= 1'b1;
                                live_reg  <= live_reg + 1'b1;
                            end
                            else status_reg <= ST_FULL;
                        end
                        OP_EVICT:
                        begin
                            if (vic_found_reg)
                            begin
                                act_reg      <= 1'b1;
                                kind_reg     <= K_DROP;
                                tgt_reg      <= vic_idx_reg;
                                tgt_rank_reg <= vic_rank_reg;
                                victim_reg   <= vic_key_reg;
                                valid_reg[vic_idx_reg] <= 1'b0;
                                live_reg     <= live_reg - 1'b1;
                            end
                            else status_reg <= ST_EMPTY;
                        end
                        default:
                        begin
                            if (hit_reg)
                            begin
                                act_reg      <= 1'b1;
                                kind_reg     <= K_DROP;
                                tgt_reg      <= hit_idx_reg;
                                tgt_rank_reg <= hit_rank_reg;
                                valid_reg[hit_idx_reg] <= 1'b0;
                                live_reg     <= live_reg - 1'b1;
                            end
                            else status_reg <= ST_MISS;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // live count tracks valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        live_reg == LIVE_BITS'($countones(valid_reg)))
        else $error("live count out of step with valid bits");

    // no request accepted while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("request accepted with result pending");

    // the memory is written only in the insert step or update
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_ACT || state_reg == S_UPD))
        else $error("stray memory write");
endmodule

// ----- test/tb.sv -----
// testbench for the lfu eviction policy table with a scoreboard class
`timescale 1ns / 1ps
module tb;
    import lfu_pkg::*;

    // expected result of one request
    typedef struct {
        logic [1:0]          status;
        logic [KEY_BITS-1:0] victim;
    } lfu_result_t;

    // predictor of the table plus queue of expected results
    class lfu_scoreboard;
        bit                    valid_q[CAPACITY];
        logic [KEY_BITS-1:0]   key_q[CAPACITY];
        logic [COUNT_BITS-1:0] cnt_q[CAPACITY];
        int unsigned           rank_q[CAPACITY];
        int unsigned           live;
        lfu_result_t           pending[$];
        int                    errors;
        int                    checked;
        int                    n_evicted;
        int                    n_full;
        int                    n_empty;
        int                    n_sat;

        function int find_slot(logic [KEY_BITS-1:0] k);
            for (int i = 0; i < CAPACITY; i++)
                if (valid_q[i] && key_q[i] == k)
                    return i;
            return -1;
        endfunction

        function void make_recent(int s);
            int unsigned r;
            r = rank_q[s];
            for (int i = 0; i < CAPACITY; i++)
                if (i != s && valid_q[i] && rank_q[i] < r)
                    rank_q[i]++;
            rank_q[s] = 0;
        endfunction

        function void drop_slot(int s);
            int unsigned r;
            r = rank_q[s];
            valid_q[s] = 0;
            for (int i = 0; i < CAPACITY; i++)
                if (valid_q[i] && rank_q[i] > r)
                    rank_q[i]--;
            if (live > 0)
                live--;
        endfunction

        // note an accepted request and predict its result
        function void note_request(logic [1:0] op, logic [KEY_BITS-1:0] k);
            lfu_result_t res;
            int s;
            int f;
            res.status = ST_OK;
            res.victim = '0;
            case (op)
                OP_GET:
                begin
                    s = find_slot(k);
                    if (s < 0)
                        res.status = ST_MISS;
                    else
                    begin
                        if (cnt_q[s] != COUNT_MAX)
                            cnt_q[s]++;
                        else
                            n_sat++;
                        make_recent(s);
                    end
                end
                OP_SET:
                begin
                    s = find_slot(k);
                    if (s >= 0)
                    begin
                        cnt_q[s] = 1;
                        make_recent(s);
                    end
                    else
                    begin
                        f = -1;
                        for (int i = CAPACITY - 1; i >= 0; i--)
                            if (!valid_q[i])
                                f = i;
                        if (f < 0)
                        begin
                            res.status = ST_FULL;
                            n_full++;
                        end
                        else
                        begin
                            for (int j = 0; j < CAPACITY; j++)
                                if (valid_q[j])
                                    rank_q[j]++;
                            valid_q[f] = 1;
                            key_q[f] = k;
                            cnt_q[f] = 1;
                            rank_q[f] = 0;
                            live++;
                        end
                    end
                end
                OP_EVICT:
                begin
                    s = -1;
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (!valid_q[i])
                            continue;
                        if (s < 0 || cnt_q[i] < cnt_q[s] ||
                            (cnt_q[i] == cnt_q[s] && rank_q[i] > rank_q[s]))
                            s = i;
                    end
                    if (s < 0)
                    begin
                        res.status = ST_EMPTY;
                        n_empty++;
                    end
                    else
                    begin
                        res.victim = key_q[s];
                        drop_slot(s);
                        n_evicted++;
                    end
                end
                default:
                begin
                    s = find_slot(k);
                    if (s < 0)
                        res.status = ST_MISS;
                    else
                        drop_slot(s);
                end
            endcase
            pending.push_back(res);
        endfunction

        // compare one result with the oldest expectation
        function void check_result(logic [1:0] st, logic [KEY_BITS-1:0] vk);
            lfu_result_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d victim=%h", $time, st, vk);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (vk !== e.victim)
            begin
                $display("%0t: victim_key expected %h actual %h", $time, e.victim, vk);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    lfu_scoreboard sb;
    bit            calm;
    bit            hold_off;
    logic [KEY_BITS-1:0] key_pool[8];

    lfu_eviction_policy_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // send one request, with random idle cycles before it
    task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] k);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, k, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(op, k);
    endtask

    // key drawn mostly from a small pool so that hits are common
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(99) < 80)
            return key_pool[$urandom_range(7)];
        return {$urandom, $urandom};
    endfunction

    // result side: random stalls, and a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                m_tready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // result sampling
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[1:0], m_tdata[65:2]);

    // run limit
    initial
    begin
        #20ms;
        $display("FAIL lfu_eviction_policy_table");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [1:0] op;
        int         wait_cycles;
        sb = new();
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        rst_n     = 1'b0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        for (int i = 0; i < 8; i++)
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty evict, misses, fill to full, overflow, tie-break, remove
        send_request(OP_EVICT, '1);
        send_request(OP_GET, '0);
        send_request(OP_REMOVE, '1);
        for (int i = 0; i < CAPACITY; i++)
            send_request(OP_SET, (i == 0) ? '0 : (i == 1) ? '1 : KEY_BITS'(64'hA5A5_0000 + i));
        send_request(OP_SET, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(OP_SET, '1);
        send_request(OP_GET, '0);
        send_request(OP_REMOVE, KEY_BITS'(64'hA5A5_0005));
        send_request(OP_EVICT, '0);
        send_request(OP_EVICT, '0);

        // long get run on a single key, no idling
        calm = 1'b1;
        for (int i = 0; i < 40; i++)
            send_request(OP_GET, '1);

        // receiver holds off while requests keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_request(OP_SET, key_pool[i]);
        join
        calm = 1'b0;

        // random: mostly sets and gets on pooled keys
        for (int n = 0; n < 380; n++)
        begin
            calm = (n >= 200 && n < 260);
            wait_cycles = $urandom_range(99);
            if (wait_cycles < 35)
                op = OP_SET;
            else if (wait_cycles < 70)
                op = OP_GET;
            else if (wait_cycles < 85)
                op = OP_EVICT;
            else
                op = OP_REMOVE;
            send_request(op, pick_key());
        end
        calm = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (100) @(posedge clk);
        $display("covered %0d results: %0d evictions, %0d full sets, %0d empty evicts",
                 sb.checked, sb.n_evicted, sb.n_full, sb.n_empty);
        $display("count saturation hits: %0d, long output stall included", sb.n_sat);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS lfu_eviction_policy_table");
        else
            $display("FAIL lfu_eviction_policy_table");
        $finish;
    end
endmodule
